// ===== rtl/core/ucb1_pkg.sv =====
// Shared types and constants for the UCB1 child selector.
// Used by every module of the block; depends on nothing else.
package ucb1_pkg;

   localparam int WINS_W   = 32;
   localparam int VISITS_W = 24;
   localparam int INDEX_W  = 8;
   localparam int SCORE_W  = 32;
   localparam int CONST_W  = 16;
   localparam int DIVD_W   = 40;
   localparam int LOG_W    = 21;
   localparam int ROOT_W   = 20;

   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   localparam logic [CONST_W-1:0] EXPLORATION_RESET = 16'd362;
   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   typedef struct packed {
      logic [WINS_W-1:0]   wins;
      logic [VISITS_W-1:0] child_visits;
      logic [VISITS_W-1:0] parent_visits;
      logic                last;
      logic                infinite;
   } item_type;

   typedef struct packed {
      logic [INDEX_W-1:0] best_index;
      logic [SCORE_W-1:0] best_score;
      logic               best_infinite;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXPLOIT,
      ST_NORM,
      ST_LOG,
      ST_LNMUL,
      ST_RATIO_GO,
      ST_RATIO,
      ST_SQRT,
      ST_EXPLORE,
      ST_SUM,
      ST_UPDATE,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/core/ucb1_front.sv =====
// Front end: a two-entry queue of incoming children, each marked as infinite or not.
// Depends on ucb1_pkg.
module ucb1_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [ucb1_pkg::WINS_W-1:0]      child_wins,
   input  logic [ucb1_pkg::VISITS_W-1:0]    child_visits,
   input  logic [ucb1_pkg::VISITS_W-1:0]    parent_visits,
   input  logic                             last_child,
   output logic                             head_valid,
   output ucb1_pkg::item_type               head,
   input  logic                             pop
);
   import ucb1_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;
   item_type   incoming;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      incoming.wins          = child_wins;
      incoming.child_visits  = child_visits;
      incoming.parent_visits = parent_visits;
      incoming.last          = last_child;
      incoming.infinite      = (child_visits == '0) || (parent_visits == '0);
   end

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

// ===== rtl/core/ucb1_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on ucb1_pkg.
module ucb1_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ucb1_pkg::DIVD_W-1:0]   dividend,
   input  logic [ucb1_pkg::VISITS_W-1:0] divisor,
   output logic                          done,
   output logic [ucb1_pkg::DIVD_W-1:0]   quotient
);
   import ucb1_pkg::*;

   logic [VISITS_W-1:0] rem_ff;
   logic [DIVD_W-1:0]   quo_ff;
   logic [VISITS_W-1:0] div_ff;
   logic [5:0]          cnt_ff;
   logic                busy_ff, done_ff;
   logic [VISITS_W:0]   shifted;
   logic                fits;

   assign shifted  = {rem_ff, quo_ff[DIVD_W-1]};
   assign fits     = (shifted >= {1'b0, div_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'(DIVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? VISITS_W'(shifted - {1'b0, div_ff}) : shifted[VISITS_W-1:0];
         quo_ff <= {quo_ff[DIVD_W-2:0], fits};
      end
   end

endmodule

// ===== rtl/core/ucb1_engine.sv =====
// Back end: sequencer that scores one child at a time and keeps the running best.
// Depends on ucb1_pkg and ucb1_div.
module ucb1_engine #(
   parameter int MAX_CHILDREN = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ucb1_pkg::CONST_W-1:0] exploration_const,
   input  logic                         head_valid,
   input  ucb1_pkg::item_type           head,
   output logic                         pop,
   input  logic                         out_free,
   output logic                         emit,
   output ucb1_pkg::result_type         result
);
   import ucb1_pkg::*;

   localparam int POS_W = $clog2(MAX_CHILDREN + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_CHILDREN);

   state_type state_ff, state_in;
   item_type  item_ff;

   logic [POS_W-1:0]   pos_ff;
   logic               have_ff;
   logic               best_inf_ff;
   logic [SCORE_W-1:0] best_score_ff;
   logic [POS_W-1:0]   best_pos_ff;

   logic [DIVD_W-1:0]  exploit_ff;
   logic [30:0]        mant_ff;
   logic [4:0]         exp_ff;
   logic [15:0]        frac_ff;
   logic [4:0]         cnt_ff;
   logic [LOG_W-1:0]   lnp_ff;
   logic [DIVD_W-1:0]  x_ff;
   logic [23:0]        rem_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [27:0]        explore_ff;
   logic [SCORE_W-1:0] score_ff;
   logic               inf_ff;

   logic               in_range, go_calc, better;
   logic               div_start, div_done;
   logic [DIVD_W-1:0]  div_dividend, div_quotient;
   logic [61:0]        square;
   logic [31:0]        sq_top;
   logic [52:0]        ln_prod;
   logic [23:0]        rem_next, trial;
   logic [35:0]        explore_prod;
   logic [DIVD_W:0]    sum;

   ucb1_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  ((state_ff == ST_IDLE) ? head.child_visits : item_ff.child_visits),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign in_range     = (pos_ff < POS_LIMIT);
   assign go_calc      = !head.infinite && in_range;
   assign square       = mant_ff * mant_ff;
   assign sq_top       = square[61:30];
   assign ln_prod      = {exp_ff, frac_ff} * LN2_Q32;
   assign rem_next     = {rem_ff[21:0], x_ff[DIVD_W-1:DIVD_W-2]};
   assign trial        = {2'b00, root_ff, 2'b01};
   assign explore_prod = exploration_const * root_ff;
   assign sum          = {1'b0, exploit_ff} + (DIVD_W + 1)'(explore_ff);

   always_comb begin
      if (!have_ff) begin
         better = 1'b1;
      end else if (inf_ff) begin
         better = !best_inf_ff;
      end else begin
         better = !best_inf_ff && (score_ff > best_score_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               state_in = go_calc ? ST_EXPLOIT : ST_UPDATE;
            end
         end
         ST_EXPLOIT: begin
            if (div_done) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (mant_ff[30]) begin
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            if (cnt_ff == 5'd1) begin
               state_in = ST_LNMUL;
            end
         end
         ST_LNMUL:    state_in = ST_RATIO_GO;
         ST_RATIO_GO: state_in = ST_RATIO;
         ST_RATIO: begin
            if (div_done) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (cnt_ff == 5'd1) begin
               state_in = ST_EXPLORE;
            end
         end
         ST_EXPLORE: state_in = ST_SUM;
         ST_SUM:     state_in = ST_UPDATE;
         ST_UPDATE:  state_in = item_ff.last ? ST_EMIT : ST_IDLE;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      div_start    = 1'b0;
      emit         = 1'b0;
      div_dividend = {head.wins, 8'b0};
      case (state_ff)
         ST_IDLE: begin
            pop       = head_valid;
            div_start = head_valid && go_calc;
         end
         ST_RATIO_GO: begin
            div_start    = 1'b1;
            div_dividend = {3'b000, lnp_ff, 16'b0};
         end
         ST_EMIT: emit = out_free;
         default: ;
      endcase
   end

   always_comb begin
      if (have_ff) begin
         result.best_index    = INDEX_W'(best_pos_ff);
         result.best_score    = best_score_ff;
         result.best_infinite = best_inf_ff;
      end else begin
         result = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         have_ff       <= 1'b0;
         best_inf_ff   <= 1'b0;
         best_score_ff <= '0;
         best_pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_UPDATE && in_range) begin
            pos_ff <= pos_ff + POS_W'(1);
            if (better) begin
               have_ff       <= 1'b1;
               best_inf_ff   <= inf_ff;
               best_score_ff <= score_ff;
               best_pos_ff   <= pos_ff;
            end
         end
         if (emit) begin
            pos_ff        <= '0;
            have_ff       <= 1'b0;
            best_inf_ff   <= 1'b0;
            best_score_ff <= '0;
            best_pos_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            item_ff  <= head;
            inf_ff   <= head.infinite;
            score_ff <= SCORE_MAX;
            mant_ff  <= {head.parent_visits, 7'b0};
            exp_ff   <= 5'd23;
         end
         ST_EXPLOIT: begin
            exploit_ff <= div_quotient;
            frac_ff    <= '0;
            cnt_ff     <= 5'd16;
         end
         ST_NORM: begin
            if (!mant_ff[30]) begin
               mant_ff <= {mant_ff[29:0], 1'b0};
               exp_ff  <= exp_ff - 5'd1;
            end
         end
         ST_LOG: begin
            cnt_ff  <= cnt_ff - 5'd1;
            frac_ff <= {frac_ff[14:0], sq_top[31]};
            mant_ff <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
         end
         ST_LNMUL: lnp_ff <= ln_prod[52:32];
         ST_RATIO: begin
            x_ff    <= div_quotient;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= 5'(ROOT_W);
         end
         ST_SQRT: begin
            cnt_ff <= cnt_ff - 5'd1;
            x_ff   <= {x_ff[DIVD_W-3:0], 2'b00};
            if (rem_next >= trial) begin
               rem_ff  <= rem_next - trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_next;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         ST_EXPLORE: explore_ff <= explore_prod[35:8];
         ST_SUM: begin
            score_ff <= (sum[DIVD_W:SCORE_W] != '0) ? SCORE_MAX : sum[SCORE_W-1:0];
         end
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset) emit |-> out_free)
      else $error("Result issued while the output slot is occupied.");

   assert property (@(posedge clock) disable iff (reset) pos_ff <= POS_LIMIT)
      else $error("Child position ran past its limit.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && !item_ff.last) |=> (state_ff == ST_IDLE))
      else $error("A non-final child did not return the sequencer to idle.");

endmodule

// ===== rtl/core/ucb1_child_selector.sv =====
// UCB1 child selector: children of one tree node are pushed one per transaction on
// the req_ queue port (wins in Q24.8, child and parent visit counts, last_child flag).
// A front queue of two entries takes children while the back end scores the current one.
// The back end computes wins/visits plus C*sqrt(ln(parent)/visits) with one shared
// 40-step divider, a normalizer of up to 23 steps, 16 squaring steps for log2
// and a 20-step root. The scoring time of a finite child varies only with the normalizer;
// a child with zero visits or zero parent visits skips the arithmetic. The running maximum
// is strict, so the first child keeps a tie. After the child marked last, one result
// (best_index, best_score in Q16.16, and best_infinite) passes through the emit state,
// once the output register is free, into that register, read on the rsp_ queue port.
// The result sits in an output register; while the receiver does not pop it, the
// front and back end keep working on the next run and stall only on its final child.
// The exploration constant C (Q8.8, csr_ register 0) resets to 362 and must be
// written only while the block is idle. Reset clears the queues, the running best
// and the child position.
// Depends on ucb1_pkg, ucb1_front, ucb1_engine.
module ucb1_child_selector #(
   parameter int MAX_CHILDREN = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [ucb1_pkg::WINS_W-1:0]   req_child_wins,
   input  logic [ucb1_pkg::VISITS_W-1:0] req_child_visits,
   input  logic [ucb1_pkg::VISITS_W-1:0] req_parent_visits,
   input  logic                          req_last_child,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [ucb1_pkg::INDEX_W-1:0]  rsp_best_index,
   output logic [ucb1_pkg::SCORE_W-1:0]  rsp_best_score,
   output logic                          rsp_best_infinite,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import ucb1_pkg::*;

   logic [CONST_W-1:0] const_ff;
   logic               out_valid_ff;
   result_type         out_ff;
   logic               head_valid, pop, emit, out_free;
   item_type           head;
   result_type         result;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {16'b0, const_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         const_ff <= EXPLORATION_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         const_ff <= csr_pwdata[CONST_W-1:0];
      end
   end

   ucb1_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .full          (req_full),
      .child_wins    (req_child_wins),
      .child_visits  (req_child_visits),
      .parent_visits (req_parent_visits),
      .last_child    (req_last_child),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop)
   );

   ucb1_engine #(
      .MAX_CHILDREN (MAX_CHILDREN)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .exploration_const (const_ff),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop),
      .out_free          (out_free),
      .emit              (emit),
      .result            (result)
   );

   assign out_free = !out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= result;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_best_index    = out_ff.best_index;
   assign rsp_best_score    = out_ff.best_score;
   assign rsp_best_infinite = out_ff.best_infinite;

endmodule

// ===== bench/tb_ucb1_child_selector.sv =====
// Self-checking testbench for the UCB1 child selector: scores streamed children with
// its own fixed-point predictor and compares every result transaction in order.
// Depends on ucb1_pkg and ucb1_child_selector.
`timescale 1ns / 1ps

module tb_ucb1_child_selector;
   import ucb1_pkg::*;

   localparam int MAXC = 256;
   localparam int WATCH_LIMIT = 40000;

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   logic [WINS_W-1:0] req_child_wins = '0;
   logic [VISITS_W-1:0] req_child_visits = '0;
   logic [VISITS_W-1:0] req_parent_visits = '0;
   logic req_last_child = 0;
   logic rsp_empty;
   logic rsp_pop = 0;
   logic [INDEX_W-1:0] rsp_best_index;
   logic [SCORE_W-1:0] rsp_best_score;
   logic rsp_best_infinite;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   ucb1_child_selector DUT (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Predictor state.
   logic [15:0] weight_c = EXPLORATION_RESET;
   logic [31:0] lead_score = '0;
   logic lead_inf = 0;
   logic [31:0] lead_pos = '0;
   logic [31:0] next_pos = '0;
   logic lead_valid = 0;
   result_type winners[$];

   int errors = 0;
   int children_sent = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   bit hold_pop = 0;

   function automatic logic [63:0] log2_fixed(logic [31:0] p);
      logic [63:0] m, frac;
      int top;
      top = 0;
      frac = 0;
      for (int b = 0; b < 32; b++) if (p[b]) top = b;
      m = 64'(p) << (30 - top);
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(top) << 16) | frac;
   endfunction

   function automatic logic [63:0] int_root(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   task automatic score_child(input logic [31:0] w, input logic [23:0] v,
                              input logic [23:0] p, input logic last);
      logic [63:0] exploit, lnp, root, total;
      logic [127:0] prod;
      logic inf, better;
      logic [31:0] sc;
      result_type r;
      if (next_pos < MAXC) begin
         inf = (v == 0 || p == 0);
         sc = SCORE_MAX;
         if (!inf) begin
            exploit = (64'(w) << 8) / v;
            prod = 128'(log2_fixed(32'(p))) * 128'(LN2_Q32);
            lnp = 64'(prod >> 32);
            root = int_root((lnp << 16) / v);
            total = exploit + ((64'(weight_c) * root) >> 8);
            sc = (total > 64'(SCORE_MAX)) ? SCORE_MAX : total[31:0];
         end
         if (!lead_valid) better = 1;
         else if (inf) better = !lead_inf;
         else better = !lead_inf && sc > lead_score;
         if (better) begin
            lead_valid = 1;
            lead_inf = inf;
            lead_score = sc;
            lead_pos = next_pos;
         end
         next_pos++;
      end
      if (last) begin
         r.best_index = lead_valid ? lead_pos[7:0] : '0;
         r.best_score = lead_valid ? lead_score : '0;
         r.best_infinite = lead_valid ? lead_inf : 1'b0;
         winners.push_back(r);
         lead_valid = 0;
         lead_inf = 0;
         lead_score = 0;
         lead_pos = 0;
         next_pos = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int short_gap();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   bit burst_mode = 0;

   task automatic send_child(input logic [31:0] w, input logic [23:0] v,
                             input logic [23:0] p, input logic last);
      int g;
      g = burst_mode ? 0 : short_gap();
      if (g != 0) begin
         req_push <= 0;
         repeat (g) @(posedge clock);
      end
      req_push <= 1;
      req_child_wins <= w;
      req_child_visits <= v;
      req_parent_visits <= p;
      req_last_child <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      score_child(w, v, p, last);
      children_sent++;
   endtask

   // Result checker and receiver stalls.
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (winners.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_best_index), 32'd0);
         end else begin
            exp_r = winners.pop_front();
            if (rsp_best_index !== exp_r.best_index)
               report_mismatch("best_index", 32'(rsp_best_index), 32'(exp_r.best_index));
            if (rsp_best_score !== exp_r.best_score)
               report_mismatch("best_score", rsp_best_score, exp_r.best_score);
            if (rsp_best_infinite !== exp_r.best_infinite)
               report_mismatch("best_infinite", 32'(rsp_best_infinite),
                               32'(exp_r.best_infinite));
         end
      end
   end

   initial begin
      int g;
      @(negedge reset);
      forever begin
         if (hold_pop) begin
            rsp_pop <= 0;
            @(posedge clock);
         end else begin
            g = short_gap();
            if (g != 0) begin
               rsp_pop <= 0;
               repeat (g) @(posedge clock);
            end
            rsp_pop <= 1;
            @(posedge clock);
         end
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("watchdog expired");
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_weight(input logic [15:0] c);
      @(posedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= 3'd0;
      csr_pwdata <= 32'(c);
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      weight_c = c;
   endtask

   task automatic drain();
      req_push <= 0;
      while (winners.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_visits();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom_range(1, 20));
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      send_child(32'd0, 24'd0, 24'd0, 1);
      send_child(32'hFFFFFFFF, 24'd1, 24'hFFFFFF, 1);
      send_child(32'hFFFFFFFF, 24'd1, 24'd1, 0);
      send_child(32'd100, 24'd0, 24'd5, 0);
      send_child(32'd100, 24'd0, 24'd5, 1);
      send_child(32'd256, 24'd1, 24'd1, 0);
      send_child(32'd256, 24'd1, 24'd1, 1);
      send_child(32'd512, 24'd4, 24'd0, 0);
      send_child(32'h00ABCDEF, 24'hFFFFFF, 24'hFFFFFF, 1);
      send_child(32'd1000, 24'd3, 24'd9, 0);
      send_child(32'd5000, 24'd7, 24'd9, 0);
      send_child(32'd10, 24'd2, 24'd9, 1);
   endtask

   task automatic test_overlong_run();
      for (int i = 0; i < MAXC + 4; i++)
         send_child($urandom, 24'($urandom_range(1, 50)), 24'd300,
                    i == MAXC + 3);
   endtask

   task automatic test_random_runs(input int count);
      int n, len;
      logic [23:0] parent;
      n = 0;
      while (n < count) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6);
         parent = ($urandom_range(0, 15) == 0) ? 24'd0 : rand_visits();
         for (int i = 0; i < len; i++) begin
            send_child($urandom, rand_visits(),
                       ($urandom_range(0, 9) == 0) ? rand_visits() : parent,
                       i == len - 1);
            n++;
         end
      end
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_pop = 1;
            repeat (3000) @(posedge clock);
            hold_pop = 0;
         end
      join_none
      burst_mode = 1;
      for (int i = 0; i < 16; i++)
         send_child($urandom, 24'($urandom_range(0, 9)), 24'd77, i[0]);
      burst_mode = 0;
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      test_directed();
      drain();
      write_weight(16'd0);
      test_random_runs(150);
      drain();
      write_weight(16'hFFFF);
      test_random_runs(150);
      drain();
      write_weight(16'd1);
      test_overlong_run();
      drain();
      write_weight(16'($urandom));
      test_backpressure();
      write_weight(EXPLORATION_RESET);
      test_random_runs(650);
      drain();
      $display("Sent %0d children and checked %0d results over five weight settings,",
               children_sent, results_seen);
      $display("including overlong runs, infinite scores and a long receiver stall.");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/core/ucb1_pkg.sv
rtl/core/ucb1_front.sv
rtl/core/ucb1_div.sv
rtl/core/ucb1_engine.sv
rtl/core/ucb1_child_selector.sv
bench/tb_ucb1_child_selector.sv
